### sv/dof_pkg.sv
// ----------------------------------------------------------------------------
// dof_pkg
// Shared types and codes for the DHCP option finder: controller states,
// command and status bundles, option and result codes.
// ----------------------------------------------------------------------------
package dof_pkg;

   // option codes with special meaning
   localparam logic [7:0] CODE_PAD      = 8'd0;
   localparam logic [7:0] CODE_END      = 8'd255;
   localparam logic [7:0] CODE_OVERLOAD = 8'd52;

   // result status codes
   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   // region codes
   localparam logic [1:0] REGION_OPTIONS = 2'd0;
   localparam logic [1:0] REGION_FILE    = 2'd1;
   localparam logic [1:0] REGION_SNAME   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_CODE_RD,
      ST_CODE_EVAL,
      ST_LEN_RD,
      ST_LEN_EVAL,
      ST_OVL_RD,
      ST_OVL_EVAL,
      ST_DONE
   } state_type;

   // which byte of an option the store read fetches
   typedef enum logic [1:0] {
      RD_CODE,
      RD_LEN,
      RD_OVL
   } rd_sel_type;

   typedef struct packed {
      logic       load_byte;     // input transfer this cycle
      logic       init;          // restart scan at options region
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       load_code;
      logic       load_len;
      logic       step_one;      // pad: advance by one
      logic       skip_now;      // advance past option, length from read data
      logic       skip_saved;    // advance past option, saved length
      logic       apply_ovl;     // merge overload bits
      logic       enter_file;
      logic       enter_sname;
      logic       load_result;
      logic [1:0] result_status;
   } cmd_type;

   typedef struct packed {
      logic at_end;      // no bytes left in region
      logic is_pad;
      logic is_end;
      logic len_out;     // length byte would lie past region
      logic overrun;     // option data past region
      logic match;
      logic is_overload;
      logic file_ok;
      logic sname_ok;
   } status_type;

endpackage

### sv/dof_ctrl.sv
// ----------------------------------------------------------------------------
// dof_ctrl
// Sequencer for the option scan: accepts bytes, steps the datapath through
// code, length and overload reads, and holds the result handshake.
// ----------------------------------------------------------------------------
module dof_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_byte,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  dof_pkg::status_type stat,
   output dof_pkg::cmd_type    cmd
);
   import dof_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last_byte) state_in = ST_INIT;
         end
         ST_INIT: state_in = ST_CODE_RD;
         ST_CODE_RD: begin
            if (stat.at_end) begin
               result_in = STATUS_MALFORMED;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_CODE_EVAL;
            end
         end
         ST_CODE_EVAL: begin
            if (stat.is_pad) begin
               state_in = ST_CODE_RD;
            end else if (stat.is_end) begin
               if (stat.file_ok || stat.sname_ok) begin
                  state_in = ST_CODE_RD;
               end else begin
                  result_in = STATUS_NOT_FOUND;
                  state_in  = ST_DONE;
               end
            end else if (stat.len_out) begin
               result_in = STATUS_MALFORMED;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_LEN_RD;
            end
         end
         ST_LEN_RD: state_in = ST_LEN_EVAL;
         ST_LEN_EVAL: begin
            if (stat.overrun) begin
               result_in = STATUS_MALFORMED;
               state_in  = ST_DONE;
            end else if (stat.match) begin
               result_in = STATUS_FOUND;
               state_in  = ST_DONE;
            end else if (stat.is_overload) begin
               state_in = ST_OVL_RD;
            end else begin
               state_in = ST_CODE_RD;
            end
         end
         ST_OVL_RD:   state_in = ST_OVL_EVAL;
         ST_OVL_EVAL: state_in = ST_CODE_RD;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd               = '0;
      cmd.rd_sel        = RD_CODE;
      cmd.result_status = result_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: cmd.load_byte = req_valid;
         ST_INIT: cmd.init = 1'b1;
         ST_CODE_RD: begin
            cmd.rd_en  = !stat.at_end;
            cmd.rd_sel = RD_CODE;
         end
         ST_CODE_EVAL: begin
            cmd.load_code = 1'b1;
            if (stat.is_pad) begin
               cmd.step_one = 1'b1;
            end else if (stat.is_end) begin
               cmd.enter_file  = stat.file_ok;
               cmd.enter_sname = !stat.file_ok && stat.sname_ok;
            end
         end
         ST_LEN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LEN;
         end
         ST_LEN_EVAL: begin
            cmd.load_len = 1'b1;
            cmd.skip_now = !stat.overrun && !stat.match && !stat.is_overload;
         end
         ST_OVL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_OVL;
         end
         ST_OVL_EVAL: begin
            cmd.apply_ovl  = 1'b1;
            cmd.skip_saved = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         result_ff    <= STATUS_NOT_FOUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/dof_dpath.sv
// ----------------------------------------------------------------------------
// dof_dpath
// Packet store, scan pointer, region and overload flags, and the result
// register of the option finder.
// ----------------------------------------------------------------------------
module dof_dpath #(
   parameter int OPTIONS_BYTES = 308,
   parameter int FILE_BYTES    = 128,
   parameter int SNAME_BYTES   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dof_pkg::cmd_type    cmd,
   output dof_pkg::status_type stat,
   input  logic [1:0]          req_region,
   input  logic [8:0]          req_byte_offset,
   input  logic [7:0]          req_byte_value,
   input  logic [7:0]          req_wanted_code,
   input  logic                req_last_byte,
   output logic [1:0]          rsp_status,
   output logic [1:0]          rsp_found_region,
   output logic [8:0]          rsp_data_offset,
   output logic [7:0]          rsp_data_length
);
   import dof_pkg::*;

   localparam int DEPTH      = OPTIONS_BYTES + FILE_BYTES + SNAME_BYTES;
   localparam int MAX_A      = (OPTIONS_BYTES > FILE_BYTES) ? OPTIONS_BYTES : FILE_BYTES;
   localparam int MAX_REGION = (MAX_A > SNAME_BYTES) ? MAX_A : SNAME_BYTES;
   // pointer holds region size plus a full option skip
   localparam int PTR_W      = $clog2(MAX_REGION + 258);
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SUM_W      = ((ADDR_W > PTR_W) ? ADDR_W : PTR_W) + 1;

   function automatic logic [PTR_W-1:0] region_size(input logic [1:0] r);
      case (r)
         REGION_OPTIONS: region_size = PTR_W'(OPTIONS_BYTES);
         REGION_FILE:    region_size = PTR_W'(FILE_BYTES);
         REGION_SNAME:   region_size = PTR_W'(SNAME_BYTES);
         default:        region_size = '0;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] r,
                                                    input logic [PTR_W-1:0] pos);
      logic [SUM_W-1:0] base;
      logic [SUM_W-1:0] sum;
      case (r)
         REGION_FILE:  base = SUM_W'(OPTIONS_BYTES);
         REGION_SNAME: base = SUM_W'(OPTIONS_BYTES + FILE_BYTES);
         default:      base = '0;
      endcase
      sum        = base + SUM_W'(pos);
      store_addr = sum[ADDR_W-1:0];
   endfunction

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [1:0]       region_ff, region_in;
   logic [3:0]       flags_ff, flags_in;
   logic [7:0]       code_ff, search_ff, len_ff;
   logic [1:0]       rsp_status_ff, rsp_region_ff;
   logic [8:0]       rsp_offset_ff;
   logic [7:0]       rsp_length_ff;

   logic [PTR_W-1:0] wr_off, cur_size, ptr1, ptr2, rd_pos, opt_end;
   logic             wr_en;
   logic [1:0]       ovl_bits;

   assign wr_off   = PTR_W'(req_byte_offset);
   assign wr_en    = cmd.load_byte && (wr_off < region_size(req_region));
   assign cur_size = region_size(region_ff);
   assign ptr1     = ptr_ff + PTR_W'(1);
   assign ptr2     = ptr_ff + PTR_W'(2);
   assign opt_end  = ptr2 + PTR_W'(rd_data_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_CODE: rd_pos = ptr_ff;
         RD_LEN:  rd_pos = ptr1;
         RD_OVL:  rd_pos = ptr2;
         default: rd_pos = ptr_ff;
      endcase
   end

   // overload byte past the region counts as zero
   assign ovl_bits = (ptr2 >= cur_size) ? 2'b00 : rd_data_ff[1:0];

   always_comb begin
      stat.at_end      = (ptr_ff >= cur_size);
      stat.is_pad      = (rd_data_ff == CODE_PAD);
      stat.is_end      = (rd_data_ff == CODE_END);
      stat.len_out     = (ptr1 >= cur_size);
      stat.overrun     = (opt_end > cur_size);
      stat.match       = (code_ff == search_ff);
      stat.is_overload = (code_ff == CODE_OVERLOAD);
      stat.file_ok     = flags_ff[0] && !flags_ff[2];
      stat.sname_ok    = flags_ff[1] && !flags_ff[3];
   end

   // store: one write port for loading, one registered read for the scan
   always_ff @(posedge clock) begin
      if (wr_en) mem[store_addr(req_region, wr_off)] <= req_byte_value;
      if (cmd.rd_en) rd_data_ff <= mem[store_addr(region_ff, rd_pos)];
   end

   always_comb begin
      ptr_in    = ptr_ff;
      region_in = region_ff;
      flags_in  = flags_ff;
      if (cmd.init) begin
         ptr_in    = '0;
         region_in = REGION_OPTIONS;
         flags_in  = '0;
      end else if (cmd.enter_file) begin
         ptr_in    = '0;
         region_in = REGION_FILE;
         flags_in  = flags_ff | 4'b0100;
      end else if (cmd.enter_sname) begin
         ptr_in    = '0;
         region_in = REGION_SNAME;
         flags_in  = flags_ff | 4'b1000;
      end else if (cmd.step_one) begin
         ptr_in = ptr1;
      end else if (cmd.skip_now) begin
         ptr_in = opt_end;
      end else if (cmd.skip_saved) begin
         ptr_in = ptr2 + PTR_W'(len_ff);
      end
      if (cmd.apply_ovl) flags_in = flags_ff | {2'b00, ovl_bits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         region_ff <= REGION_OPTIONS;
         flags_ff  <= '0;
         search_ff <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         region_ff <= region_in;
         flags_ff  <= flags_in;
         if (cmd.load_byte && req_last_byte) search_ff <= req_wanted_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_code) code_ff <= rd_data_ff;
      if (cmd.load_len) len_ff <= rd_data_ff;
      if (cmd.load_result) begin
         rsp_status_ff <= cmd.result_status;
         if (cmd.result_status == STATUS_FOUND) begin
            rsp_region_ff <= region_ff;
            rsp_offset_ff <= ptr2[8:0];
            rsp_length_ff <= len_ff;
         end else begin
            rsp_region_ff <= '0;
            rsp_offset_ff <= '0;
            rsp_length_ff <= '0;
         end
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_found_region = rsp_region_ff;
   assign rsp_data_offset  = rsp_offset_ff;
   assign rsp_data_length  = rsp_length_ff;

endmodule

### sv/dhcp_option_finder_top.sv
// ----------------------------------------------------------------------------
// dhcp_option_finder_top
// Stores the options, file and sname bytes of one DHCP packet and, after the
// last byte, looks up one option code, following overload into file and
// sname.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+-----------------------------------------------------
//  req_     | in        | valid/ready, region, byte_offset, byte_value,
//           |           | wanted_code, last_byte
//  rsp_     | out       | valid/ready, status, found_region, data_offset,
//           |           | data_length
//
//  Bytes load one transfer per cycle into a single-port-write store.
//  The scan is bound by the store's registered read: each code, length or
//  overload byte is read, then evaluated, between init and the result post.
//  While scanning req_ready is low; the result sits in an output register,
//  so new bytes are taken while it waits on rsp_ready.
//  Reset (synchronous) clears control state only; store contents are
//  undefined until written.
// ----------------------------------------------------------------------------
module dhcp_option_finder_top #(
   parameter int OPTIONS_BYTES = 308,
   parameter int FILE_BYTES    = 128,
   parameter int SNAME_BYTES   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_region,
   input  logic [8:0] req_byte_offset,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_wanted_code,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_found_region,
   output logic [8:0] rsp_data_offset,
   output logic [7:0] rsp_data_length
);
   import dof_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // sequencer: owns both handshakes
   dof_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // store, scan registers and result register
   dof_dpath #(
      .OPTIONS_BYTES (OPTIONS_BYTES),
      .FILE_BYTES    (FILE_BYTES),
      .SNAME_BYTES   (SNAME_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_region       (req_region),
      .req_byte_offset  (req_byte_offset),
      .req_byte_value   (req_byte_value),
      .req_wanted_code  (req_wanted_code),
      .req_last_byte    (req_last_byte),
      .rsp_status       (rsp_status),
      .rsp_found_region (rsp_found_region),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_data_length  (rsp_data_length)
   );

endmodule
